FILE: hw/rtl/sstf_pkg.sv
package sstf_pkg;

  localparam int MAX_REQUESTS_DEF  = 64;
  localparam int CYLINDER_BITS_DEF = 16;

  // Largest running total that the result field can show; the sum saturates here.
  localparam logic [21:0] TOTAL_MAX = 22'h3F_FFFF;

  typedef struct packed {
    logic [15:0] request_cylinder;
    logic        last_request;
  } req_item_t;

  typedef struct packed {
    logic [15:0] served_cylinder;
    logic [15:0] seek_distance;
    logic [21:0] total_seek;
    logic        last_served;
  } rsp_item_t;

  // Broadcast commands from the controller to every cell of the row.
  typedef struct packed {
    logic load;   // Store the write cylinder in the cell that matches the write index.
    logic clear;  // Clear every served flag when the last request of a batch is taken.
    logic mark;   // Set the served flag of the cell that matches the mark index.
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/sstf_disk_request_scheduler.sv
// Once a batch is loaded, no request is taken until its last result is issued.
// Each result waits until the candidate wave, which walks the row of cells one
// cell per cycle, has passed every cell since the last change of head or served
// flags, and until the output register is free. Requests load one per cycle while a batch loads.
// Reset (synchronous, active high) clears the control state, the served flags and
// start_head; stored cylinders are not cleared and no clearing pass is needed.
module sstf_disk_request_scheduler #(
  parameter int MAX_REQUESTS  = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int CYLINDER_BITS = sstf_pkg::CYLINDER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [15:0]         cfg_data,
  input  logic                req_valid,
  output logic                req_stall,
  input  sstf_pkg::req_item_t req_item,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sstf_pkg::rsp_item_t rsp_item
);
  import sstf_pkg::*;

  localparam int IDX_W     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W     = $clog2(MAX_REQUESTS + 1);
  localparam int CYL_EXT_W = (CYLINDER_BITS > 16) ? CYLINDER_BITS : 16;
  localparam int SUM_W     = ((CYLINDER_BITS > 22) ? CYLINDER_BITS : 22) + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_REQUESTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_REQUESTS - 1);

  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } state_t;

  state_t state;

  // The start position of the head is taken whenever the port writes it.
  logic [CYLINDER_BITS-1:0] start_head;
  logic [CNT_W-1:0]         count;       // requests held in the current batch
  logic [CNT_W-1:0]         served_num;  // results already delivered in this batch
  logic [CNT_W-1:0]         scan_cnt;    // cycles since the row state last changed
  logic [CYLINDER_BITS-1:0] head;
  logic [21:0]              total;

  // The candidate chain: entry 0 feeds the first cell with "nothing found", and
  // entry MAX_REQUESTS is the registered output of the last cell.
  logic                     cand_found [0:MAX_REQUESTS];
  logic [CYLINDER_BITS-1:0] cand_dist  [0:MAX_REQUESTS];
  logic [IDX_W-1:0]         cand_idx   [0:MAX_REQUESTS];
  logic [CYLINDER_BITS-1:0] cand_cyl   [0:MAX_REQUESTS];

  cell_ctrl_t               ctrl;
  logic                     req_xfer;
  logic                     batch_end;
  logic                     emit;
  logic                     emit_last;
  logic [CYL_EXT_W-1:0]     req_cyl_ext;
  logic [CYL_EXT_W-1:0]     cfg_ext;
  logic [CYL_EXT_W-1:0]     best_cyl_ext;
  logic [SUM_W-1:0]         dist_ext;
  logic [SUM_W-1:0]         sum;
  logic [21:0]              total_next;

  // Requests are taken only while a batch is being loaded; results of the
  // previous batch may still wait in the output register meanwhile.
  assign req_stall = (state != ST_LOAD);
  assign req_xfer  = req_valid && !req_stall;

  // The batch closes on a marked request or when the row is full.
  assign batch_end = req_item.last_request || (count == CNT_LAST);

  // A pick is final once the wave has passed every cell since the last change
  // of head or served flags. It is delivered when the output register is free.
  assign emit      = (state == ST_SCAN) && (scan_cnt == CNT_FULL) &&
                     (!rsp_valid || !rsp_stall);
  assign emit_last = (served_num + CNT_W'(1)) == count;

  assign req_cyl_ext  = CYL_EXT_W'(req_item.request_cylinder);
  assign cfg_ext      = CYL_EXT_W'(cfg_data);
  assign best_cyl_ext = CYL_EXT_W'(cand_cyl[MAX_REQUESTS]);
  assign dist_ext     = SUM_W'(cand_dist[MAX_REQUESTS]);

  // The running total saturates at the largest value its field can hold.
  assign sum        = SUM_W'(total) + dist_ext;
  assign total_next = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[21:0];

  always_comb begin
    ctrl.load  = req_xfer;
    ctrl.clear = req_xfer && batch_end;
    ctrl.mark  = emit;
  end

  assign cand_found[0] = 1'b0;
  assign cand_dist[0]  = '0;
  assign cand_idx[0]   = '0;
  assign cand_cyl[0]   = '0;

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    sstf_cell #(
      .IDX           (i),
      .MAX_REQUESTS  (MAX_REQUESTS),
      .CYLINDER_BITS (CYLINDER_BITS),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .wr_idx        (count[IDX_W-1:0]),
      .wr_cyl        (req_cyl_ext[CYLINDER_BITS-1:0]),
      .mark_idx      (cand_idx[MAX_REQUESTS]),
      .count         (count),
      .head          (head),
      .cand_found_in (cand_found[i]),
      .cand_dist_in  (cand_dist[i]),
      .cand_idx_in   (cand_idx[i]),
      .cand_cyl_in   (cand_cyl[i]),
      .cand_found    (cand_found[i+1]),
      .cand_dist     (cand_dist[i+1]),
      .cand_idx      (cand_idx[i+1]),
      .cand_cyl      (cand_cyl[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_item.served_cylinder <= best_cyl_ext[15:0];
      rsp_item.seek_distance   <= dist_ext[15:0];
      rsp_item.total_seek      <= total_next;
      rsp_item.last_served     <= emit_last;
    end
    if (rst) begin
      state      <= ST_LOAD;
      start_head <= '0;
      count      <= '0;
      served_num <= '0;
      scan_cnt   <= '0;
      head       <= '0;
      total      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        start_head <= cfg_ext[CYLINDER_BITS-1:0];
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (req_xfer) begin
            count <= count + CNT_W'(1);
            if (batch_end) begin
              // The head restarts from the configured position for every batch.
              head       <= start_head;
              total      <= '0;
              served_num <= '0;
              scan_cnt   <= '0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (emit) begin
            head       <= cand_cyl[MAX_REQUESTS];
            total      <= total_next;
            served_num <= served_num + CNT_W'(1);
            scan_cnt   <= '0;
            if (emit_last) begin
              count <= '0;
              state <= ST_LOAD;
            end
          end else if (scan_cnt != CNT_FULL) begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/sstf_cell.sv
module sstf_cell #(
  parameter int IDX           = 0,
  parameter int MAX_REQUESTS  = 64,
  parameter int CYLINDER_BITS = 16,
  parameter int IDX_W         = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1,
  parameter int CNT_W         = $clog2(MAX_REQUESTS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sstf_pkg::cell_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [CYLINDER_BITS-1:0] wr_cyl,
  input  logic [IDX_W-1:0]         mark_idx,
  input  logic [CNT_W-1:0]         count,
  input  logic [CYLINDER_BITS-1:0] head,
  input  logic                     cand_found_in,
  input  logic [CYLINDER_BITS-1:0] cand_dist_in,
  input  logic [IDX_W-1:0]         cand_idx_in,
  input  logic [CYLINDER_BITS-1:0] cand_cyl_in,
  output logic                     cand_found,
  output logic [CYLINDER_BITS-1:0] cand_dist,
  output logic [IDX_W-1:0]         cand_idx,
  output logic [CYLINDER_BITS-1:0] cand_cyl
);
  import sstf_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [CYLINDER_BITS-1:0] cyl;
  logic                     served;
  logic [CYLINDER_BITS-1:0] own_dist;
  logic                     eligible;
  logic                     take;

  assign own_dist = (head >= cyl) ? (head - cyl) : (cyl - head);
  assign eligible = (MY_CNT < count) && !served;
  // Strictly smaller wins, so the earlier cell keeps a tie.
  assign take     = eligible && (!cand_found_in || (own_dist < cand_dist_in));

  always_ff @(posedge clk) begin
    if (ctrl.load && (wr_idx == MY_IDX)) begin
      cyl <= wr_cyl;
    end
    cand_dist <= take ? own_dist : cand_dist_in;
    cand_idx  <= take ? MY_IDX   : cand_idx_in;
    cand_cyl  <= take ? cyl      : cand_cyl_in;
    if (rst) begin
      served     <= 1'b0;
      cand_found <= 1'b0;
    end else begin
      cand_found <= cand_found_in || eligible;
      if (ctrl.clear) begin
        served <= 1'b0;
      end else if (ctrl.mark && (mark_idx == MY_IDX)) begin
        served <= 1'b1;
      end
    end
  end

endmodule
